>>> hw/rtl/fixed_point_square_root_core_macros.svh
// Assertion macros shared by the square root RTL.
// Needs clock and reset signals in the scope where the macros are used.
`ifndef FIXED_POINT_SQUARE_ROOT_CORE_MACROS_SVH
`define FIXED_POINT_SQUARE_ROOT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPSR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/fpsr_pkg.sv
// Package for the fixed-point square root core: widths, constants and the
// data record handed from one root cell to the next. No dependencies.
`default_nettype none

package fpsr_pkg;

   localparam int unsigned ROOT_W     = 16;
   localparam int unsigned RAD_W      = 2 * ROOT_W;
   localparam int unsigned FRAC_W     = 5;
   localparam int unsigned NUM_CELLS  = ROOT_W;

   localparam logic [FRAC_W-1:0] FRAC_MAX   = FRAC_W'(16);
   localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(8);
   localparam logic [ROOT_W-1:0] ALL_ONES   = '1;

   // Partial remainder and root estimate moving down the cell chain.
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [RAD_W-1:0] rem;
      logic [RAD_W-1:0] acc;
   } fpsr_stage_type;

endpackage

`default_nettype wire

>>> hw/rtl/fpsr_cell.sv
// One cell of the square root chain: settles a single root bit and registers
// the updated remainder and estimate. Depends on fpsr_pkg.
`default_nettype none

module fpsr_cell
   import fpsr_pkg::*;
#(
   parameter int unsigned STEP = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  fpsr_stage_type      stage_i,
   output fpsr_stage_type      stage_o
);

   localparam int unsigned    SHIFT   = RAD_W - 2 - 2 * STEP;
   localparam logic [RAD_W-1:0] BIT_VAL = {{(RAD_W-1){1'b0}}, 1'b1} << SHIFT;

   logic             valid_ff, valid_in;
   logic             zero_ff,  zero_in;
   logic [RAD_W-1:0] rem_ff,   rem_in;
   logic [RAD_W-1:0] acc_ff,   acc_in;
   logic [RAD_W:0]   trial;
   logic             fits;

   // Trial subtrahend is the current estimate plus this cell's bit weight.
   always_comb begin
      trial    = {1'b0, stage_i.acc} + {1'b0, BIT_VAL};
      fits     = {1'b0, stage_i.rem} >= trial;
      valid_in = stage_i.valid;
      zero_in  = stage_i.zero;
      if (fits) begin
         rem_in = stage_i.rem - trial[RAD_W-1:0];
         acc_in = (stage_i.acc >> 1) + BIT_VAL;
      end else begin
         rem_in = stage_i.rem;
         acc_in = stage_i.acc >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
   end

   assign stage_o = '{valid: valid_ff, zero: zero_ff, rem: rem_ff, acc: acc_ff};

endmodule

`default_nettype wire

>>> hw/rtl/fixed_point_square_root_core.sv
// Fixed-point square root core: root = floor(sqrt(radicand << min(frac_bits, 16))).
// A request passes the entry register, the cell chain and the output register before rsp_strobe is high.
// The 16-cell chain holds one item at a time; the next start is taken only once busy drops.
// The result is shown for one cycle and cannot be stalled by the receiver.
// Synchronous active-high reset empties the chain, drops busy and sets frac_bits to 8.
// Depends on fpsr_pkg, fpsr_cell and fixed_point_square_root_core_macros.svh.
`default_nettype none

`include "fixed_point_square_root_core_macros.svh"

module fixed_point_square_root_core
   import fpsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   // Request channel: a transaction is taken when start is high and busy is low.
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [ROOT_W-1:0] req_radicand,

   // Response channel: one-cycle strobe, no back-pressure.
   output logic                   rsp_strobe,
   output logic [ROOT_W-1:0]      rsp_root,
   output logic                   rsp_zero_input,

   // Configuration write channel for frac_bits.
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [FRAC_W-1:0] csr_data
);

   // ------------------------------------------------------------------
   // Configuration register. The register is always ready; software is
   // expected to write it only while no transaction is in flight. Values
   // above sixteen are kept as written and saturated where they are used.
   // ------------------------------------------------------------------
   logic [FRAC_W-1:0] frac_bits_ff, frac_bits_in;
   logic [FRAC_W-1:0] shift_amt;

   assign csr_ready = 1'b1;

   always_comb begin
      frac_bits_in = frac_bits_ff;
      if (csr_valid && csr_ready) begin
         frac_bits_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_bits_ff <= FRAC_RESET;
      end else begin
         frac_bits_ff <= frac_bits_in;
      end
   end

   assign shift_amt = (frac_bits_ff > FRAC_MAX) ? FRAC_MAX : frac_bits_ff;

   // ------------------------------------------------------------------
   // Entry stage. An accepted transaction is scaled into a 32-bit radicand
   // and parked here as the head of the chain with a zero estimate.
   // ------------------------------------------------------------------
   logic             accept;
   logic             busy_ff, busy_in;
   logic             entry_valid_ff, entry_valid_in;
   logic             entry_zero_ff;
   logic [RAD_W-1:0] entry_rem_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   assign entry_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_zero_ff <= (req_radicand == '0);
         entry_rem_ff  <= {{(RAD_W-ROOT_W){1'b0}}, req_radicand} << shift_amt;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain. Cell k decides root bit 15-k and hands the remainder and
   // estimate to cell k+1 on the next edge.
   // ------------------------------------------------------------------
   fpsr_stage_type          chain [NUM_CELLS+1];
   logic [NUM_CELLS:0]      chain_valid;

   assign chain[0] = '{valid: entry_valid_ff, zero: entry_zero_ff,
                       rem: entry_rem_ff, acc: '0};

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      fpsr_cell #(
         .STEP (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .stage_i (chain[k]),
         .stage_o (chain[k+1])
      );
   end

   for (genvar k = 0; k <= NUM_CELLS; k++) begin : g_valid
      assign chain_valid[k] = chain[k].valid;
   end

   // Busy covers the whole flight of a transaction through the chain; it
   // drops on the edge at which the last cell's result enters the output
   // register, so the next start can be taken in the strobe cycle.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (chain[NUM_CELLS].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register. A zero radicand reports the all-ones code and raises
   // the zero flag; otherwise the settled estimate is the floor root.
   // ------------------------------------------------------------------
   logic              rsp_strobe_ff;
   logic [ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_zero_ff;

   assign rsp_root_in = chain[NUM_CELLS].zero ? ALL_ONES : chain[NUM_CELLS].acc[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= chain[NUM_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chain[NUM_CELLS].valid) begin
         rsp_root_ff <= rsp_root_in;
         rsp_zero_ff <= chain[NUM_CELLS].zero;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_zero_input = rsp_zero_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `FPSR_ASSERT_NEXT(a_accept_sets_busy, accept, busy_ff, "busy not raised after accept")
   `FPSR_ASSERT_NOW(a_single_token, 1'b1, $countones(chain_valid) <= 1, "more than one item in chain")
   `FPSR_ASSERT_NOW(a_busy_tracks_chain, 1'b1, busy_ff == (|chain_valid), "busy out of step with chain")
   `FPSR_ASSERT_NOW(a_strobe_idle, rsp_strobe_ff, !busy_ff, "response shown while busy")
   `FPSR_ASSERT_NOW(a_zero_code, rsp_strobe_ff && rsp_zero_ff, rsp_root_ff == ALL_ONES, "zero input without all-ones code")

endmodule

`default_nettype wire

>>> tb/sv/fixed_point_square_root_core_test.sv
// Self-checking testbench for fixed_point_square_root_core: random and directed radicands
// under several frac_bits settings, each root predicted in the bench. Needs fpsr_pkg and the RTL.
`timescale 1ns / 100ps

module fixed_point_square_root_core_test;
   import fpsr_pkg::*;

   // One expected response transaction: the root code and the zero-radicand flag.
   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              zero_input;
   } sqrt_result_type;

   localparam int unsigned NUM_PHASES      = 9;
   localparam int unsigned ITEMS_PER_PHASE = 48;
   localparam int unsigned DRAIN_CYCLES    = 24;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [ROOT_W-1:0] req_radicand = '0;
   logic              rsp_strobe;
   logic [ROOT_W-1:0] rsp_root;
   logic              rsp_zero_input;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FRAC_W-1:0] csr_data = '0;

   // Radicands waiting to be issued, and the roots predicted for transactions already taken.
   logic [ROOT_W-1:0] pending_radicands[$];
   sqrt_result_type   expected_roots[$];

   // Bench copy of the frac_bits register, updated when a write is accepted.
   logic [FRAC_W-1:0] frac_setting = FRAC_RESET;

   // Chance, in percent, that the request driver leaves a cycle empty.
   int unsigned       sender_idle_pct = 0;
   int unsigned       mismatch_count  = 0;

   fixed_point_square_root_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_radicand   (req_radicand),
      .rsp_strobe     (rsp_strobe),
      .rsp_root       (rsp_root),
      .rsp_zero_input (rsp_zero_input),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Floor square root of the radicand scaled by 2^frac, found one result bit at a time
   // from the top by testing whether the candidate squared still fits under the scaled
   // value. Settings above sixteen act as sixteen, and a zero radicand gives the
   // all-ones code with the flag raised.
   function automatic sqrt_result_type predict_root(logic [ROOT_W-1:0] radicand,
                                                    logic [FRAC_W-1:0] frac);
      sqrt_result_type   res;
      int unsigned       shift;
      logic [63:0]       scaled;
      logic [63:0]       trial;
      logic [ROOT_W-1:0] estimate;
      shift = (frac > FRAC_MAX) ? FRAC_MAX : frac;
      scaled = 64'(radicand) << shift;
      estimate = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = 64'(estimate | (ROOT_W'(1) << b));
         if (trial * trial <= scaled) begin
            estimate = trial[ROOT_W-1:0];
         end
      end
      if (radicand == '0) begin
         res.root       = ALL_ONES;
         res.zero_input = 1'b1;
      end else begin
         res.root       = estimate;
         res.zero_input = 1'b0;
      end
      return res;
   endfunction

   // Every mismatch is counted; only the first ten are printed in full.
   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endfunction

   // Request driver. A transaction is taken at an edge where start is high and busy is
   // low; its root is predicted right then with the current frac_bits copy. A raised start
   // stays high while the block is busy, so its radicand is held until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_roots.push_back(predict_root(req_radicand, frac_setting));
         end
         if (!(start && busy)) begin
            if (pending_radicands.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               start        <= 1'b1;
               req_radicand <= pending_radicands.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor. The strobe lasts exactly one cycle and cannot be held off, so
   // each strobed cycle is one transaction, checked against the oldest prediction.
   always @(posedge clock) begin
      sqrt_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_roots.size() == 0) begin
            note_mismatch($sformatf("unexpected response root=%0d zero_input=%0b",
                                    rsp_root, rsp_zero_input));
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root !== want.root) begin
               note_mismatch($sformatf("root expected %0d, got %0d (frac_bits %0d)",
                                       want.root, rsp_root, frac_setting));
            end
            if (rsp_zero_input !== want.zero_input) begin
               note_mismatch($sformatf("zero_input expected %0b, got %0b",
                                       want.zero_input, rsp_zero_input));
            end
         end
      end
   end

   // Holds until every queued radicand has been issued and every response has come
   // back, then lets the pipeline settle. This is also where the sender pauses fully.
   task automatic wait_until_idle();
      do @(posedge clock);
      while (pending_radicands.size() > 0 || start || expected_roots.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes frac_bits over the configuration channel and waits for the handshake.
   task automatic write_frac_bits(logic [FRAC_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      frac_setting = value;
      csr_valid <= 1'b0;
   endtask

   // Random radicands: half full-range values, with small values, zeros and perfect
   // squares mixed in so the low end and exact roots are hit often.
   task automatic queue_random_radicands(int unsigned count);
      int unsigned pick;
      int unsigned k;
      for (int unsigned i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            pending_radicands.push_back(ROOT_W'($urandom_range(65535)));
         end else if (pick < 70) begin
            pending_radicands.push_back(ROOT_W'($urandom_range(255)));
         end else if (pick < 78) begin
            pending_radicands.push_back('0);
         end else begin
            k = $urandom_range(255);
            pending_radicands.push_back(ROOT_W'(k * k));
         end
      end
   endtask

   // Edge cases: zero, one, the top code, the sign-bit boundary and a few squares.
   task automatic queue_directed_radicands();
      pending_radicands.push_back(16'h0000);
      pending_radicands.push_back(16'h0001);
      pending_radicands.push_back(16'h0002);
      pending_radicands.push_back(16'h0003);
      pending_radicands.push_back(16'h0004);
      pending_radicands.push_back(16'h7FFF);
      pending_radicands.push_back(16'h8000);
      pending_radicands.push_back(16'hFFFE);
      pending_radicands.push_back(16'hFFFF);
      pending_radicands.push_back(16'h5555);
      pending_radicands.push_back(16'hAAAA);
      pending_radicands.push_back(16'h4000);
   endtask

   // Main sequence. The first phase runs at the reset value of frac_bits; the others
   // write a new setting first, covering both extremes, the saturated range above
   // sixteen, and random values. Sender idling changes every three phases: 35 percent,
   // then 62 percent, then none.
   initial begin
      logic [FRAC_W-1:0] phase_frac[NUM_PHASES];
      phase_frac[0] = FRAC_RESET;
      phase_frac[1] = '0;
      phase_frac[2] = FRAC_MAX;
      phase_frac[3] = '1;
      phase_frac[4] = FRAC_W'(17);
      phase_frac[5] = FRAC_W'(1);
      phase_frac[6] = FRAC_W'(15);
      phase_frac[7] = FRAC_W'($urandom_range(31));
      phase_frac[8] = FRAC_W'($urandom_range(16));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            write_frac_bits(phase_frac[p]);
         end
         case (p / 3)
            0: begin
               sender_idle_pct = 35;
            end
            1: begin
               sender_idle_pct = 62;
            end
            default: begin
               sender_idle_pct = 0;
            end
         endcase
         // The directed set goes in at both extremes of the fraction position.
         if (p == 1 || p == 2) begin
            queue_directed_radicands();
         end
         queue_random_radicands(ITEMS_PER_PHASE);
         wait_until_idle();
      end

      while (expected_roots.size() > 0) begin
         note_mismatch("expected response never arrived");
         void'(expected_roots.pop_front());
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_600_000;
      $display("FAIL");
      $finish;
   end

endmodule
